>>> sv/spqw_pkg.sv
// Shared types and constants for the stable priority queue with walk-in entries.
// Holds the request and response payload structs and the key ordering function.
// No dependencies.
package spqw_pkg;

   // Width of the key and tag fields
   localparam int unsigned KEY_W = 16;
   localparam int unsigned TAG_W = 16;

   // Key value that marks a walk-in entry
   localparam logic [KEY_W-1:0] WALK_IN_KEY = 16'hFFFF;

   typedef enum logic {
      MODE_ENQ = 1'b0,
      MODE_DEQ = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      mode_type                mode;
      logic [TAG_W-1:0]        entry_tag;
      logic signed [KEY_W-1:0] appt_time;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [TAG_W-1:0] served_tag;
   } rsp_type;

   // One stored queue entry
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // True when a new key must stand ahead of a stored key
   function automatic logic goes_before(input logic [KEY_W-1:0] new_key,
                                        input logic [KEY_W-1:0] old_key);
      logic result;
      result = 1'b0;
      if (new_key == WALK_IN_KEY) begin
         result = 1'b0;
      end else if (old_key == WALK_IN_KEY) begin
         result = 1'b1;
      end else begin
         result = ($signed(old_key) > $signed(new_key));
      end
      return result;
   endfunction

endpackage

>>> sv/stable_priority_queue_walkin_unit.sv
// Sorted queue with walk-in entries, kept in one single-port-write memory ring.
// Depends on spqw_pkg for payload types, status codes and key ordering.
// Dequeue reads the head and answers from S_DEQ; enqueue walks from the tail, moving entries up one place;
// enqueue into an empty queue, full enqueue and empty dequeue answer straight from S_IDLE.
// One request in flight; the insertion walk, one memory read and write per cycle, sets the rate.
// Reset: synchronous, clears count, ring head and handshake state; memory is not cleared.
module stable_priority_queue_walkin_unit #(
   parameter int unsigned DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spqw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spqw_pkg::rsp_type rsp_data
);
   import spqw_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W = DEPTH[AW:0];
   localparam logic [CW-1:0] DEPTH_C = DEPTH[CW-1:0];

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEQ,
      S_ENQ,
      S_PUT,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     cur_ff, cur_in;
   entry_type         new_ff, new_in;
   rsp_type           pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Queue memory
   entry_type         mem [DEPTH];
   entry_type         rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;
   entry_type         mem_wdata;

   logic              fin;
   rsp_type           fin_data;
   logic              slot_free;
   entry_type         req_entry;

   // Map a position in the queue to a ring address
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] idx);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, idx};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_entry = '{key: req_data.appt_time, tag: req_data.entry_tag};

   // Sequence one request through the memory
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      head_in   = head_ff;
      cur_in    = cur_ff;
      new_in    = new_ff;
      pend_in   = pend_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_raddr = '0;
      mem_wdata = new_ff;
      fin       = 1'b0;
      fin_data  = '{status: STATUS_DONE, served_tag: '0};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == MODE_DEQ) begin
                  if (count_ff == '0) begin
                     fin             = 1'b1;
                     fin_data.status = STATUS_EMPTY;
                  end else begin
                     // Read the head and retire it
                     mem_raddr = head_ff;
                     head_in   = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     count_in  = count_ff - 1'b1;
                     state_in  = S_DEQ;
                  end
               end else begin
                  if (count_ff == DEPTH_C) begin
                     fin             = 1'b1;
                     fin_data.status = STATUS_FULL;
                  end else if (count_ff == '0) begin
                     mem_we    = 1'b1;
                     mem_waddr = head_ff;
                     mem_wdata = req_entry;
                     count_in  = CW'(1);
                     fin       = 1'b1;
                  end else begin
                     // Start the walk from the tail
                     mem_raddr = phys(head_ff, AW'(count_ff - 1'b1));
                     cur_in    = count_ff[AW-1:0];
                     new_in    = req_entry;
                     count_in  = count_ff + 1'b1;
                     state_in  = S_ENQ;
                  end
               end
            end
         end
         S_DEQ: begin
            fin                 = 1'b1;
            fin_data.served_tag = rdata_ff.tag;
         end
         S_ENQ: begin
            mem_we    = 1'b1;
            mem_waddr = phys(head_ff, cur_ff);
            if (goes_before(new_ff.key, rdata_ff.key)) begin
               // Move the stored entry up one place and keep walking
               mem_wdata = rdata_ff;
               cur_in    = cur_ff - 1'b1;
               mem_raddr = phys(head_ff, cur_ff - AW'(2));
               if (cur_ff == AW'(1)) begin
                  state_in = S_PUT;
               end
            end else begin
               mem_wdata = new_ff;
               fin       = 1'b1;
            end
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = head_ff;
            mem_wdata = new_ff;
            fin       = 1'b1;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hand the result to the output register or hold it
      if (fin) begin
         if (slot_free) begin
            state_in = S_IDLE;
         end else begin
            pend_in  = fin_data;
            state_in = S_DONE;
         end
      end
   end

   // Load the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (fin && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_data;
      end else if (state_ff == S_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_ff;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      new_ff      <= new_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Write and read the queue memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Entry count stays within the queue depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_C)
      else $error("entry count beyond depth");

   // The walk never writes position zero while still comparing
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ENQ |-> cur_ff != '0)
      else $error("insertion walk passed the head");

   // A dequeue of an empty queue leaves it empty
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.mode == MODE_DEQ && count_ff == '0)
      |=> count_ff == '0)
      else $error("empty dequeue changed the count");

   // During the walk the write never hits the address being read
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENQ && state_in == S_ENQ) |-> mem_waddr != mem_raddr)
      else $error("walk read and write collide");

endmodule

>>> tb/sv/stable_priority_queue_walkin_unit_test.sv
// Self-checking testbench for the sorted queue with walk-in entries.
// Drives random and directed enqueue/dequeue requests and checks every response.
// Depends on spqw_pkg and stable_priority_queue_walkin_unit.
module stable_priority_queue_walkin_unit_test;
   import spqw_pkg::*;

   localparam int unsigned DEPTH       = 16;
   localparam int unsigned ITEM_TARGET = 1550;
   localparam int unsigned HOLD_AT     = 400;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_WAIT  = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Requests still to send, predicted responses, and the modeled queue contents
   req_type   request_q[$];
   rsp_type   outcome_q[$];
   entry_type waiting_line[$];

   bit failed    = 1'b0;
   bit tx_calm   = 1'b0;
   bit rx_calm   = 1'b0;
   int send_gap  = 0;
   int recv_gap  = 0;
   int sent_cnt  = 0;
   int recv_cnt  = 0;
   int num_items = 0;

   stable_priority_queue_walkin_unit #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // New key stands ahead of a stored key: walk-ins go last, else signed order
   function automatic bit ranks_ahead(input logic [KEY_W-1:0] new_key,
                                      input logic [KEY_W-1:0] old_key);
      if (new_key == WALK_IN_KEY) return 1'b0;
      if (old_key == WALK_IN_KEY) return 1'b1;
      return $signed(old_key) > $signed(new_key);
   endfunction

   // Apply one request to the modeled queue and return the response it causes
   function automatic rsp_type serve_request(input req_type r);
      rsp_type outcome;
      int      slot;
      bit      found;
      outcome.status     = STATUS_DONE;
      outcome.served_tag = '0;
      if (r.mode == MODE_DEQ) begin
         if (waiting_line.size() == 0) begin
            outcome.status = STATUS_EMPTY;
         end else begin
            outcome.served_tag = waiting_line[0].tag;
            void'(waiting_line.pop_front());
         end
      end else if (waiting_line.size() >= DEPTH) begin
         outcome.status = STATUS_FULL;
      end else begin
         slot  = waiting_line.size();
         found = 1'b0;
         for (int i = 0; i < waiting_line.size(); i++) begin
            if (!found && ranks_ahead(r.appt_time, waiting_line[i].key)) begin
               slot  = i;
               found = 1'b1;
            end
         end
         waiting_line.insert(slot, '{key: r.appt_time, tag: r.entry_tag});
      end
      return outcome;
   endfunction

   task automatic queue_request(input mode_type m, input logic [TAG_W-1:0] tag,
                                input logic [KEY_W-1:0] key);
      req_type r;
      r.mode      = m;
      r.entry_tag = tag;
      r.appt_time = key;
      request_q.push_back(r);
      num_items++;
   endtask

   // Pick a key: wide random, a narrow band with many ties, or around the sign boundary
   function automatic logic [KEY_W-1:0] pick_key(input int style);
      if (style == 0) begin
         return ($urandom_range(0, 5) == 0) ? WALK_IN_KEY : 16'($urandom);
      end else if (style == 1) begin
         return ($urandom_range(0, 4) == 0) ? WALK_IN_KEY : 16'($urandom_range(0, 7));
      end
      return ($urandom_range(0, 3) == 0) ? WALK_IN_KEY
                                         : 16'(16'h7FF0 + $urandom_range(0, 31));
   endfunction

   // Send requests; hold a request until accepted, then wait the drawn gap
   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_q.push_back(serve_request(req_data));
            sent_cnt++;
            if (sent_cnt % 64 == 0) tx_calm = ($urandom_range(0, 2) == 0);
            send_gap = tx_calm ? 0 : $urandom_range(0, 3);
         end
         if (req_valid && !req_ready) begin
            req_valid <= 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (request_q.size() > 0) begin
            req_data  <= request_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Accept responses, check them in order, and stall at random
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected response status %0d tag %h",
                        $time, rsp_data.status, rsp_data.served_tag);
               failed = 1'b1;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_data.status);
                  failed = 1'b1;
               end
               if (rsp_data.served_tag !== want.served_tag) begin
                  $display("%0t: served_tag expected %h got %h",
                           $time, want.served_tag, rsp_data.served_tag);
                  failed = 1'b1;
               end
            end
            recv_cnt++;
            if (recv_cnt % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
            recv_gap = rx_calm ? 0 : $urandom_range(0, 3);
            // Hold off once for a long stretch so the block backs up its input
            if (recv_cnt == HOLD_AT) recv_gap = HOLD_CYCLES;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int phase_len;
      int enq_pct;
      int style;
      bit first_phase;

      // Directed: empty dequeue, key extremes, equal keys, walk-ins, then drain
      queue_request(MODE_DEQ, 16'hFFFF, 16'h7FFF);
      queue_request(MODE_ENQ, 16'hFFFF, WALK_IN_KEY);
      queue_request(MODE_ENQ, 16'h0001, 16'h7FFF);
      queue_request(MODE_ENQ, 16'h0002, 16'h8000);
      queue_request(MODE_ENQ, 16'h0003, 16'hFFFE);
      queue_request(MODE_ENQ, 16'h0004, 16'h0000);
      queue_request(MODE_ENQ, 16'h0005, 16'h0000);
      queue_request(MODE_ENQ, 16'h0006, WALK_IN_KEY);
      queue_request(MODE_ENQ, 16'h0000, 16'h1234);
      for (int i = 0; i < 10; i++) queue_request(MODE_DEQ, 16'(i), 16'h0000);

      // Random phases: enqueue-heavy, balanced or dequeue-heavy, varied key styles
      first_phase = 1'b1;
      while (num_items < ITEM_TARGET) begin
         phase_len = $urandom_range(20, 80);
         style     = $urandom_range(0, 2);
         case ($urandom_range(0, 2))
            0: enq_pct = 85;
            1: enq_pct = 50;
            default: enq_pct = 15;
         endcase
         // Start by filling past capacity to reach the full case early
         if (first_phase) begin
            enq_pct   = 100;
            phase_len = DEPTH + 4;
         end
         first_phase = 1'b0;
         for (int i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 99) < enq_pct) begin
               queue_request(MODE_ENQ, 16'($urandom), pick_key(style));
            end else begin
               queue_request(MODE_DEQ, 16'($urandom), 16'($urandom));
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request is sent and every response has come back
      while (request_q.size() != 0 || req_valid || outcome_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("Some tests failed");
      $finish;
   end

endmodule
